// File: rtl/asfm_pkg.sv
// Package with types and constants for the approximate single-precision multiplier.
`timescale 1ns / 1ps
`default_nettype none
package asfm_pkg;
   localparam int unsigned ExpBias = 127;
   localparam int unsigned HiBits = 13;   // 12 fraction bits plus the hidden one
   localparam int unsigned LoBits = 11;
   localparam int unsigned SumBits = 26;
   localparam logic [SumBits-1:0] RoundAdd = 26'd2;

   // Partial products handed from the multiply stage to the normalize stage.
   typedef struct packed {
      logic                 sign;
      logic [8:0]           expo;
      logic [SumBits-1:0]   sum;
   } prod_type;
endpackage
`default_nettype wire

// File: rtl/asfm_mant_mul.sv
// Sign, exponent sum and truncated mantissa product of two single-precision words.
`timescale 1ns / 1ps
`default_nettype none
module asfm_mant_mul (
   input  wire logic [31:0]         operand_a,
   input  wire logic [31:0]         operand_b,
   output asfm_pkg::prod_type       prod
);
   logic [asfm_pkg::HiBits-1:0] ha, hb;
   logic [asfm_pkg::LoBits-1:0] la, lb;
   logic [25:0] hh;
   logic [23:0] hl, lh;

   assign ha = {1'b1, operand_a[22:11]};
   assign hb = {1'b1, operand_b[22:11]};
   assign la = operand_a[10:0];
   assign lb = operand_b[10:0];
   assign hh = {13'd0, ha} * {13'd0, hb};
   assign hl = {11'd0, ha} * {13'd0, lb};
   assign lh = {13'd0, la} * {11'd0, hb};

   assign prod.sign = operand_a[31] ^ operand_b[31];
   assign prod.expo = {1'b0, operand_a[30:23]} + {1'b0, operand_b[30:23]};
   assign prod.sum  = hh + {13'd0, hl[23:11]} + {13'd0, lh[23:11]} + asfm_pkg::RoundAdd;
endmodule
`default_nettype wire

// File: rtl/asfm_norm.sv
// Normalization, underflow flush and packing of the product word.
`timescale 1ns / 1ps
`default_nettype none
module asfm_norm (
   input  wire asfm_pkg::prod_type  prod,
   output logic [31:0]              product
);
   logic [9:0]  expo;
   logic [22:0] frac;
   logic [9:0]  biased;

   always_comb begin
      if (prod.sum[25]) begin
         expo = {1'b0, prod.expo} + 10'd1;
         frac = prod.sum[24:2];
      end else begin
         expo = {1'b0, prod.expo};
         frac = prod.sum[23:1];
      end
      biased = expo - 10'(asfm_pkg::ExpBias);
      if (expo <= 10'(asfm_pkg::ExpBias)) begin
         product = {prod.sign, 31'd0};
      end else begin
         // Exponent bit 8 folds into the sign; higher bits drop off.
         product = {prod.sign | biased[8], biased[7:0], frac};
      end
   end
endmodule
`default_nettype wire

// File: rtl/approx_single_float_multiply_unit.sv
// Top level of the approximate single-precision multiplier.
`timescale 1ns / 1ps
`default_nettype none
// Channel  Direction  tdata fields (low bit up)
// req      in         operand_a[31:0], operand_b[63:32]
// rsp      out        product[31:0]
// One word enters per cycle while the output is not stalled. The input register
// feeds the multipliers; the products are packed into the output register.
// Reset clears both valid flags. A stalled output holds its word, and the
// input stage still advances whenever the output register is free or leaving.
module approx_single_float_multiply_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [63:0] req_tdata,   // operand_a, operand_b
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [31:0]      rsp_tdata    // product
);
   logic        in_vld_ff, out_vld_ff;
   logic [63:0] in_dat_ff;
   logic [31:0] out_dat_ff, out_dat_in;
   logic        adv_out, adv_in;
   asfm_pkg::prod_type prod;

   assign adv_out = !out_vld_ff || rsp_tready;
   assign adv_in  = !in_vld_ff || adv_out;
   assign req_tready = adv_in;

   asfm_mant_mul u_mul (
      .operand_a(in_dat_ff[31:0]),
      .operand_b(in_dat_ff[63:32]),
      .prod(prod)
   );
   asfm_norm u_norm (.prod(prod), .product(out_dat_in));

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         if (adv_in) in_vld_ff <= req_tvalid;
         if (adv_out) out_vld_ff <= in_vld_ff;
      end
      if (adv_in && req_tvalid) in_dat_ff <= req_tdata;
      if (adv_out && in_vld_ff) out_dat_ff <= out_dat_in;
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = out_dat_ff;

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("output word changed while stalled");
   a_move: assert property (@(posedge clock) disable iff (reset)
      in_vld_ff && adv_out |=> out_vld_ff)
      else $error("input stage word lost");
   a_ready: assert property (@(posedge clock) disable iff (reset)
      !out_vld_ff |-> req_tready)
      else $error("input stalled with empty output");
endmodule
`default_nettype wire

// File: tb/tb_approx_single_float_multiply_unit.sv
// Testbench for the approximate single-precision multiplier: random and directed operands.
`timescale 1ns / 1ps
`default_nettype none

class product_board;
   logic [31:0] pending_products[$];
   int unsigned fail_count;

   function new();
      fail_count = 0;
   endfunction

   // The expected product for two operand patterns.
   function logic [31:0] approx_product(logic [31:0] a, logic [31:0] b);
      logic        sgn;
      logic [31:0] expo;
      logic [31:0] ha, la, hb, lb, sum, frac;
      sgn = a[31] ^ b[31];
      expo = {24'd0, a[30:23]} + {24'd0, b[30:23]};
      ha = {20'd0, a[22:11]} + 32'h1000;
      la = {21'd0, a[10:0]};
      hb = {20'd0, b[22:11]} + 32'h1000;
      lb = {21'd0, b[10:0]};
      sum = ha * hb + ((ha * lb) >> 11) + ((la * hb) >> 11) + 32'd2;
      if (sum >= 32'h0200_0000) begin
         expo = expo + 32'd1;
         frac = {9'd0, sum[24:2]};
      end else begin
         frac = {9'd0, sum[23:1]};
      end
      if (expo <= 32'd127)
         return {sgn, 31'd0};
      expo = expo - 32'd127;
      return {sgn, 31'd0} | (expo << 23) | frac;
   endfunction

   function void note_operands(logic [31:0] a, logic [31:0] b);
      pending_products.push_back(approx_product(a, b));
   endfunction

   function void check_product(logic [31:0] got);
      logic [31:0] want;
      if (pending_products.size() == 0) begin
         $error("product: unexpected word %h", got);
         fail_count++;
         return;
      end
      want = pending_products.pop_front();
      if (got !== want) begin
         $error("product: expected %h, actual %h", want, got);
         fail_count++;
      end
   endfunction
endclass

module tb_approx_single_float_multiply_unit;
   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [63:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;
   longint      cycle_count = 0;
   product_board board = new();

   approx_single_float_multiply_unit i_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   always #2 clock = ~clock;

   function automatic int gap_length();
      if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
      if ($urandom_range(0, 2) == 0) return $urandom_range(1, 3);
      return 0;
   endfunction

   // Random operand; half the time its exponent is drawn from 100..154 or 60..200, else fully random.
   function automatic logic [31:0] random_operand();
      logic [31:0] v;
      v = $urandom;
      case ($urandom_range(0, 3))
         0: v[30:23] = 8'($urandom_range(100, 154));
         1: v[30:23] = 8'($urandom_range(60, 200));
         default: ;
      endcase
      return v;
   endfunction

   task automatic send_word(logic [31:0] a, logic [31:0] b);
      int gap;
      gap = gap_length();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {b, a};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      board.note_operands(a, b);
   endtask

   // Result side: random stalls, with stretches of steady readiness.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         board.check_product(rsp_tdata);
      if (reset)
         rsp_tready <= 1'b0;
      else if (cycle_count % 2000 < 300)
         rsp_tready <= 1'b1;
      else if ($urandom_range(0, 49) == 0)
         rsp_tready <= 1'b0;
      else
         rsp_tready <= $urandom_range(0, 3) != 0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > 400000) begin
         $display("** approx_single_float_multiply_unit: FAILED **");
         $finish;
      end
   end

   logic [31:0] edge_ops[12] = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h3F80_0000, 32'hBF80_0000,
                                 32'h7F80_0000, 32'h7FC0_0000, 32'h0000_0001, 32'h007F_FFFF,
                                 32'h3FFF_FFFF, 32'h7F7F_FFFF, 32'h4000_07FF, 32'hC07F_F800};

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      // Directed: edges, signs, overflow into the sign, underflow, carry to 2^25.
      for (int i = 0; i < 12; i++)
         send_word(edge_ops[i], edge_ops[(i * 5 + 3) % 12]);
      send_word(32'h3FFF_FFFF, 32'h3FFF_FFFF);
      send_word(32'h7F00_0000, 32'h7F00_0000);
      send_word(32'h3F00_0000, 32'h0080_0000);
      send_word(32'h2000_0000, 32'h1F80_0000);
      send_word(32'hFFFF_FFFF, 32'h0000_0000);
      send_word(32'h8000_0000, 32'h8000_0000);
      // Pause until every product has come back.
      req_tvalid <= 1'b0;
      while (board.pending_products.size() != 0) @(posedge clock);
      for (int n = 0; n < 1200; n++)
         send_word(random_operand(), random_operand());
      req_tvalid <= 1'b0;
      while (board.pending_products.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (board.fail_count == 0 && board.pending_products.size() == 0)
         $display("** approx_single_float_multiply_unit: PASSED **");
      else
         $display("** approx_single_float_multiply_unit: FAILED **");
      $finish;
   end
endmodule

`default_nettype wire
